// ===== hdl/fca_pkg.sv =====
// Shared types and constants for the FAT chain allocator.
// Holds field widths, link markers, status codes and register indexes.
// No dependencies.
package fca_pkg;

  localparam int unsigned BLK_W       = 12;
  localparam int unsigned NUM_BLOCKS  = 4096;
  localparam int unsigned BYTES_W     = 32;
  localparam int unsigned BSIZE_W     = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_DATA_W   = 48;
  localparam int unsigned OUT_DATA_W  = 40;

  // Link table markers.
  localparam logic [BLK_W-1:0] LINK_FREE = '0;
  localparam logic [BLK_W-1:0] LINK_END  = '1;

  // Request function codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_NOFREE = 3'd1,
    ST_RANOUT = 3'd2,
    ST_ZERO   = 3'd3,
    ST_BROKEN = 3'd4
  } status_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 4'd1;

endpackage

// ===== hdl/fat_chain_allocator_core.sv =====
// FAT chain allocator: one request in, one result out.
// Allocate: a divide, a check against the free count, then a scan that reads table entries,
// takes each free block found and links it from the previous block (every block but the
// first), then a result.
// Free: walks the chain and frees each block of it, then a result; one request at a time.
// Reset (rst_n low, synchronous) and every total_blocks write start a clear of all 4096 entries.
module fat_chain_allocator_core
  import fca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Request channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // byte_count[31:0], start_block[43:32], zero pad
  input  logic                  in_tuser,   // func
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[2:0], first_block[14:3],
                                            // blocks_done[26:15], free_left[38:27], zero pad
);

  localparam int unsigned DIV_W     = BYTES_W + 1;
  localparam int unsigned REM_W     = BSIZE_W + 1;
  localparam int unsigned DCNT_W    = $clog2(DIV_W);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_W - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DIV, S_NEED, S_SCAN, S_LINK, S_FWALK, S_DONE
  } state_t;

  // The link table: one write and one registered read per cycle.
  logic [BLK_W-1:0] link_mem [NUM_BLOCKS];
  logic             mem_we, mem_re;
  logic [BLK_W-1:0] mem_wa, mem_wd, mem_ra;
  logic [BLK_W-1:0] mem_rdata_r;

  state_t            state_r, state_nxt;
  logic [BLK_W-1:0]  total_blocks_r, total_blocks_nxt;
  logic [BSIZE_W-1:0] block_size_r, block_size_nxt;
  logic [BLK_W-1:0]  free_count_r, free_count_nxt;
  logic [BLK_W-1:0]  clr_addr_r, clr_addr_nxt;

  // Restoring divider for the allocate block count.
  logic [DIV_W-1:0]   div_q_r, div_q_nxt;
  logic [REM_W-1:0]   div_rem_r, div_rem_nxt;
  logic [BSIZE_W-1:0] div_bs_r, div_bs_nxt;
  logic [DCNT_W-1:0]  div_cnt_r, div_cnt_nxt;

  // Scan and walk bookkeeping.
  logic [BLK_W-1:0] need_r, need_nxt;
  logic [BLK_W-1:0] scan_r, scan_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [BLK_W-1:0] rd_addr_q_r, rd_addr_q_nxt;
  logic [BLK_W-1:0] prev_r, prev_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [BLK_W-1:0] found_r, found_nxt;
  logic [BLK_W-1:0] cur_r, cur_nxt;
  logic             haz_r, haz_nxt;

  // Result being built.
  status_t          status_r, status_nxt;
  logic [BLK_W-1:0] first_r, first_nxt;
  logic [BLK_W-1:0] done_r, done_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [BYTES_W-1:0] in_bytes;
  logic [BLK_W-1:0]   in_start;

  assign in_bytes = in_tdata[BYTES_W-1:0];
  assign in_start = in_tdata[BYTES_W +: BLK_W];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata_r <= link_mem[mem_ra];
    end
  end

  always_comb begin
    logic [BSIZE_W-1:0] bs_eff;
    logic [REM_W-1:0]   rem_sh;
    logic               rem_ge;
    logic [BLK_W-1:0]   walk_d;
    logic [BLK_W-1:0]   done_inc;

    state_nxt        = state_r;
    total_blocks_nxt = total_blocks_r;
    block_size_nxt   = block_size_r;
    free_count_nxt   = free_count_r;
    clr_addr_nxt     = clr_addr_r;
    div_q_nxt        = div_q_r;
    div_rem_nxt      = div_rem_r;
    div_bs_nxt       = div_bs_r;
    div_cnt_nxt      = div_cnt_r;
    need_nxt         = need_r;
    scan_nxt         = scan_r;
    rd_pend_nxt      = rd_pend_r;
    rd_addr_q_nxt    = rd_addr_q_r;
    prev_nxt         = prev_r;
    have_prev_nxt    = have_prev_r;
    found_nxt        = found_r;
    cur_nxt          = cur_r;
    haz_nxt          = haz_r;
    status_nxt       = status_r;
    first_nxt        = first_r;
    done_nxt         = done_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;

    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = LINK_FREE;
    mem_re = 1'b0;
    mem_ra = '0;

    bs_eff   = (block_size_r == '0) ? BSIZE_W'(1) : block_size_r;
    rem_sh   = {div_rem_r[REM_W-2:0], div_q_r[DIV_W-1]};
    rem_ge   = (rem_sh >= {1'b0, div_bs_r});
    walk_d   = haz_r ? LINK_FREE : mem_rdata_r;
    done_inc = done_r + BLK_W'(1);

    case (state_r)
      S_CLR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        mem_wd       = LINK_FREE;
        clr_addr_nxt = clr_addr_r + BLK_W'(1);
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          done_nxt  = '0;
          first_nxt = '0;
          if (in_tuser == FUNC_FREE) begin
            if (in_start == '0 || in_start >= total_blocks_r) begin
              status_nxt = ST_BROKEN;
              state_nxt  = S_DONE;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = in_start;
              cur_nxt   = in_start;
              haz_nxt   = 1'b0;
              state_nxt = S_FWALK;
            end
          end else if (in_bytes == '0) begin
            status_nxt = ST_ZERO;
            state_nxt  = S_DONE;
          end else begin
            // Ceiling divide as floor((bytes + bs - 1) / bs).
            div_q_nxt   = {1'b0, in_bytes} + DIV_W'(bs_eff) - DIV_W'(1);
            div_rem_nxt = '0;
            div_bs_nxt  = bs_eff;
            div_cnt_nxt = '0;
            state_nxt   = S_DIV;
          end
        end
      end

      S_DIV: begin
        div_rem_nxt = rem_ge ? (rem_sh - {1'b0, div_bs_r}) : rem_sh;
        div_q_nxt   = {div_q_r[DIV_W-2:0], rem_ge};
        div_cnt_nxt = div_cnt_r + DCNT_W'(1);
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_NEED;
        end
      end

      S_NEED: begin
        if (div_q_r > DIV_W'(free_count_r)) begin
          status_nxt = ST_NOFREE;
          state_nxt  = S_DONE;
        end else begin
          need_nxt      = div_q_r[BLK_W-1:0];
          scan_nxt      = BLK_W'(1);
          rd_pend_nxt   = 1'b0;
          have_prev_nxt = 1'b0;
          state_nxt     = S_SCAN;
        end
      end

      S_SCAN: begin
        // One read issued per cycle unless a free entry is being taken; the entry read last cycle is checked now.
        if (rd_pend_r && mem_rdata_r == LINK_FREE) begin
          mem_we         = 1'b1;
          mem_wa         = rd_addr_q_r;
          mem_wd         = LINK_END;
          free_count_nxt = free_count_r - BLK_W'(1);
          done_nxt       = done_inc;
          found_nxt      = rd_addr_q_r;
          rd_pend_nxt    = 1'b0;
          if (have_prev_r) begin
            state_nxt = S_LINK;
          end else begin
            first_nxt     = rd_addr_q_r;
            prev_nxt      = rd_addr_q_r;
            have_prev_nxt = 1'b1;
            if (done_inc == need_r) begin
              status_nxt = ST_OK;
              state_nxt  = S_DONE;
            end
          end
        end else if (scan_r < total_blocks_r) begin
          mem_re        = 1'b1;
          mem_ra        = scan_r;
          rd_addr_q_nxt = scan_r;
          rd_pend_nxt   = 1'b1;
          scan_nxt      = scan_r + BLK_W'(1);
        end else begin
          // Free count overstated the table; keep the partial chain.
          rd_pend_nxt = 1'b0;
          status_nxt  = ST_RANOUT;
          state_nxt   = S_DONE;
        end
      end

      S_LINK: begin
        mem_we   = 1'b1;
        mem_wa   = prev_r;
        mem_wd   = found_r;
        prev_nxt = found_r;
        if (done_r == need_r) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_FWALK: begin
        if (walk_d == LINK_FREE) begin
          status_nxt = ST_BROKEN;
          state_nxt  = S_DONE;
        end else begin
          mem_we = 1'b1;
          mem_wa = cur_r;
          mem_wd = LINK_FREE;
          if (free_count_r != '1) begin
            free_count_nxt = free_count_r + BLK_W'(1);
          end
          done_nxt = done_inc;
          if (walk_d == LINK_END) begin
            status_nxt = ST_OK;
            state_nxt  = S_DONE;
          end else if (walk_d >= total_blocks_r) begin
            status_nxt = ST_BROKEN;
            state_nxt  = S_DONE;
          end else begin
            // A link back to the block just freed must read as free.
            mem_re  = 1'b1;
            mem_ra  = walk_d;
            cur_nxt = walk_d;
            haz_nxt = (walk_d == cur_r);
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({free_count_r, done_r, first_r, status_r});
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Register writes; a new total_blocks reformats the table.
    if (cfg_we) begin
      if (cfg_index == CFG_TOTAL_BLOCKS) begin
        total_blocks_nxt = cfg_wdata[BLK_W-1:0];
        free_count_nxt   = (cfg_wdata[BLK_W-1:0] != '0) ?
                           (cfg_wdata[BLK_W-1:0] - BLK_W'(1)) : '0;
        clr_addr_nxt     = '0;
        state_nxt        = S_CLR;
      end else if (cfg_index == CFG_BLOCK_SIZE) begin
        block_size_nxt = cfg_wdata[BSIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLR;
      clr_addr_r     <= '0;
      total_blocks_r <= BLK_W'(4095);
      block_size_r   <= BSIZE_W'(512);
      free_count_r   <= BLK_W'(4094);
      out_valid_r    <= 1'b0;
      rd_pend_r      <= 1'b0;
      have_prev_r    <= 1'b0;
      haz_r          <= 1'b0;
      div_cnt_r      <= '0;
    end else begin
      state_r        <= state_nxt;
      clr_addr_r     <= clr_addr_nxt;
      total_blocks_r <= total_blocks_nxt;
      block_size_r   <= block_size_nxt;
      free_count_r   <= free_count_nxt;
      out_valid_r    <= out_valid_nxt;
      rd_pend_r      <= rd_pend_nxt;
      have_prev_r    <= have_prev_nxt;
      haz_r          <= haz_nxt;
      div_cnt_r      <= div_cnt_nxt;
    end
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    div_bs_r    <= div_bs_nxt;
    need_r      <= need_nxt;
    scan_r      <= scan_nxt;
    rd_addr_q_r <= rd_addr_q_nxt;
    prev_r      <= prev_nxt;
    found_r     <= found_nxt;
    cur_r       <= cur_nxt;
    status_r    <= status_nxt;
    first_r     <= first_nxt;
    done_r      <= done_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// ===== tb/sv/tb_fat_chain_allocator_core.sv =====
// Self-checking testbench for fat_chain_allocator_core: allocate and free requests
// checked against a behavioral model of the link table. Depends on fca_pkg and the core.
`timescale 1ns / 100ps

module tb_fat_chain_allocator_core;
  import fca_pkg::*;

  localparam int unsigned CLK_HALF_NS   = 2;
  localparam int unsigned RESET_CYCLES  = 7;
  // Longest single request is a full-table allocate.
  localparam int unsigned TAIL_CYCLES   = 12400;
  localparam longint      TIMEOUT_NS    = 64_000_000;

  // Register values the core comes out of reset with.
  localparam logic [CFG_DATA_W-1:0] RESET_TOTAL = 16'd4095;
  localparam logic [CFG_DATA_W-1:0] RESET_BSIZE = 16'd512;
  // An index past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0]  CFG_UNMAPPED = 4'hF;
  // The free counter stops here when a free would push it further.
  localparam logic [BLK_W-1:0]      FREE_CNT_MAX = '1;

  // One result, as the core packs it on out_tdata.
  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] first_blk;
    logic [BLK_W-1:0] blocks_done;
    logic [BLK_W-1:0] free_left;
  } alloc_result_t;

  // One directed request. Rows with typed set carry a hand-worked result; the
  // others are checked against the table model.
  typedef struct packed {
    logic                func;
    logic [BYTES_W-1:0]  bytes;
    logic [BLK_W-1:0]    start;
    logic                typed;
    alloc_result_t       want;
  } dir_row_t;

  // One random phase: register setting, request count and idling pressure.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] total;
    logic [CFG_DATA_W-1:0] bsize;
    int                    items;
    int                    gap_pct;
    int                    stall_pct;
  } phase_cfg_t;

  localparam int NUM_DIRECTED = 24;

  // Directed sequence, run with the reset settings (4095 blocks, 512 bytes per block,
  // 4094 free). The rows walk through zero-byte and oversized allocates, the ceiling
  // divide, breaks at block 0, at the end marker, at an already free block and at a
  // dangling link in the middle of a chain, first-fit reuse of holes, a full-table
  // allocate and free, and a chain that runs into a block reused by a later allocate.
  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{FUNC_ALLOC, 32'd0,          12'd0,    1'b1, '{ST_ZERO,   12'd0,    12'd0,    12'd4094}},
    '{FUNC_ALLOC, 32'd1,          12'hFFF,  1'b1, '{ST_OK,     12'd1,    12'd1,    12'd4093}},
    '{FUNC_ALLOC, 32'd512,        12'd0,    1'b1, '{ST_OK,     12'd2,    12'd1,    12'd4092}},
    '{FUNC_ALLOC, 32'd513,        12'd0,    1'b1, '{ST_OK,     12'd3,    12'd2,    12'd4090}},
    '{FUNC_ALLOC, 32'hFFFF_FFFF,  12'd0,    1'b1, '{ST_NOFREE, 12'd0,    12'd0,    12'd4090}},
    '{FUNC_FREE,  32'hFFFF_FFFF,  12'd0,    1'b1, '{ST_BROKEN, 12'd0,    12'd0,    12'd4090}},
    '{FUNC_FREE,  32'd0,          12'hFFF,  1'b1, '{ST_BROKEN, 12'd0,    12'd0,    12'd4090}},
    '{FUNC_FREE,  32'd0,          12'd4094, 1'b1, '{ST_BROKEN, 12'd0,    12'd0,    12'd4090}},
    '{FUNC_FREE,  32'd0,          12'd4,    1'b1, '{ST_OK,     12'd0,    12'd1,    12'd4091}},
    '{FUNC_FREE,  32'd0,          12'd3,    1'b1, '{ST_BROKEN, 12'd0,    12'd1,    12'd4092}},
    '{FUNC_FREE,  32'd0,          12'd3,    1'b1, '{ST_BROKEN, 12'd0,    12'd0,    12'd4092}},
    '{FUNC_FREE,  32'd0,          12'd1,    1'b1, '{ST_OK,     12'd0,    12'd1,    12'd4093}},
    '{FUNC_ALLOC, 32'd1024,       12'd0,    1'b1, '{ST_OK,     12'd1,    12'd2,    12'd4091}},
    '{FUNC_FREE,  32'd0,          12'd1,    1'b1, '{ST_OK,     12'd0,    12'd2,    12'd4093}},
    '{FUNC_FREE,  32'd0,          12'd2,    1'b1, '{ST_OK,     12'd0,    12'd1,    12'd4094}},
    '{FUNC_ALLOC, 32'd2096128,    12'd0,    1'b1, '{ST_OK,     12'd1,    12'd4094, 12'd0}},
    '{FUNC_ALLOC, 32'd1,          12'd0,    1'b1, '{ST_NOFREE, 12'd0,    12'd0,    12'd0}},
    '{FUNC_FREE,  32'd0,          12'd4094, 1'b1, '{ST_OK,     12'd0,    12'd1,    12'd1}},
    '{FUNC_ALLOC, 32'd513,        12'd0,    1'b1, '{ST_NOFREE, 12'd0,    12'd0,    12'd1}},
    '{FUNC_ALLOC, 32'd512,        12'd0,    1'b1, '{ST_OK,     12'd4094, 12'd1,    12'd0}},
    '{FUNC_FREE,  32'd0,          12'd1,    1'b1, '{ST_OK,     12'd0,    12'd4094, 12'd4094}},
    '{FUNC_ALLOC, 32'd2096129,    12'd0,    1'b1, '{ST_NOFREE, 12'd0,    12'd0,    12'd4094}},
    '{FUNC_ALLOC, 32'd5000,       12'd0,    1'b0, '{ST_OK,     12'd0,    12'd0,    12'd0}},
    '{FUNC_FREE,  32'd0,          12'd1,    1'b0, '{ST_OK,     12'd0,    12'd0,    12'd0}}
  };

  // Random phases. The first two hit the register extremes, the third runs a zero
  // block size (taken as one byte) with no random gaps or stalls, the last two are mid-range.
  localparam int NUM_PHASES = 5;
  localparam phase_cfg_t PHASES [NUM_PHASES] = '{
    '{16'd2,    16'd1,     16, 20, 20},
    '{16'd4095, 16'd65535, 20, 30, 30},
    '{16'd16,   16'd0,     20, 0,  0},
    '{16'd40,   16'd100,   30, 20, 20},
    '{16'd300,  16'd7,     30, 40, 40}
  };

  // Block ports. Every input starts at a known value.
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Model of the allocator: link table, free counter and register copies.
  logic [BLK_W-1:0] fat_links [NUM_BLOCKS];
  logic [BLK_W-1:0] fat_free_cnt;
  int unsigned      fat_total;
  int unsigned      fat_bsize;

  // Results still owed by the core, oldest first, and chain heads handed out
  // by allocates (used only to steer the stimulus toward valid frees).
  alloc_result_t    pending_results [$];
  logic [BLK_W-1:0] chain_heads [$];

  int unsigned error_count = 0;
  int          gap_pct     = 20;
  int          stall_pct   = 20;
  int          stall_left  = 0;

  fat_chain_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Register write as the model sees it. A total_blocks write reformats the table.
  function automatic void set_fat_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_TOTAL_BLOCKS) begin
      fat_total = 32'(value[BLK_W-1:0]);
      foreach (fat_links[i]) fat_links[i] = LINK_FREE;
      fat_free_cnt = (fat_total > 0) ? BLK_W'(fat_total - 1) : '0;
      chain_heads.delete();
    end else if (idx == CFG_BLOCK_SIZE) begin
      fat_bsize = 32'(value);
    end
  endfunction

  // Applies one request to the model table and returns the result it must produce.
  function automatic alloc_result_t predict_fat_request(input logic func,
                                                        input logic [BYTES_W-1:0] bytes,
                                                        input logic [BLK_W-1:0] start);
    alloc_result_t    res;
    longint unsigned  bsz;
    longint unsigned  need;
    longint unsigned  k;
    int unsigned      limit;
    int unsigned      scan;
    int unsigned      prev;
    int unsigned      cur;
    int unsigned      nxt;
    bit               have_prev;
    bit               done_walk;
    res = '0;
    res.status = ST_OK;
    limit = (fat_total < NUM_BLOCKS) ? fat_total : NUM_BLOCKS;
    if (func == FUNC_ALLOC) begin
      bsz  = (fat_bsize == 0) ? 1 : fat_bsize;
      need = ({32'd0, bytes} + bsz - 1) / bsz;
      if (bytes == 0) begin
        res.status = ST_ZERO;
      end else if (need > fat_free_cnt) begin
        res.status = ST_NOFREE;
      end else begin
        // First fit from block 1; each block found becomes the new chain tail.
        scan = 1;
        prev = 0;
        have_prev = 1'b0;
        for (k = 0; k < need; k++) begin
          while (scan < limit && fat_links[scan] != LINK_FREE) scan++;
          if (scan >= limit) begin
            // The counter promised more blocks than the table holds.
            res.status = ST_RANOUT;
            break;
          end
          fat_links[scan] = LINK_END;
          fat_free_cnt = fat_free_cnt - 1'b1;
          if (have_prev) fat_links[prev] = BLK_W'(scan);
          else res.first_blk = BLK_W'(scan);
          prev = scan;
          have_prev = 1'b1;
          res.blocks_done++;
          scan++;
        end
      end
    end else begin
      // Walk the chain, freeing as we go, until the end marker or a bad link.
      cur = 32'(start);
      done_walk = 1'b0;
      while (!done_walk) begin
        if (cur == 0 || cur >= limit || fat_links[cur] == LINK_FREE) begin
          res.status = ST_BROKEN;
          done_walk = 1'b1;
        end else begin
          nxt = 32'(fat_links[cur]);
          fat_links[cur] = LINK_FREE;
          if (fat_free_cnt != FREE_CNT_MAX) fat_free_cnt++;
          res.blocks_done++;
          if (nxt == LINK_END) done_walk = 1'b1;
          else cur = nxt;
        end
      end
    end
    res.free_left = fat_free_cnt;
    return res;
  endfunction

  // Returns 0 for no pause, else a pause length: mostly short, sometimes long.
  function automatic int pick_pause(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Builds one random request from the current table contents. Half are allocates
  // sized to fit (now and then sized at or one past the free count), three in ten are
  // frees of live chains or of blocks in the middle of one, and the rest are raw noise.
  function automatic void make_random_request(output logic func,
                                               output logic [BYTES_W-1:0] bytes,
                                               output logic [BLK_W-1:0] start);
    int unsigned     roll;
    int unsigned     limit;
    int unsigned     base;
    int unsigned     probe;
    int unsigned     idx;
    longint unsigned bsz;
    longint unsigned need;
    roll  = $urandom_range(0, 99);
    limit = (fat_total < NUM_BLOCKS) ? fat_total : NUM_BLOCKS;
    bsz   = (fat_bsize == 0) ? 1 : fat_bsize;
    // The field a function ignores still carries random bits.
    func  = FUNC_ALLOC;
    bytes = $urandom;
    start = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
    if (roll < 50) begin
      if ($urandom_range(0, 9) == 0) need = fat_free_cnt + $urandom_range(0, 1);
      else need = $urandom_range(1, 6);
      bytes = (need == 0) ? '0 :
              BYTES_W'((need - 1) * bsz + $urandom_range(1, int'(bsz)));
    end else if (roll < 80) begin
      func = FUNC_FREE;
      if (chain_heads.size() > 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, chain_heads.size() - 1);
        start = chain_heads[idx];
        chain_heads.delete(idx);
      end else if (limit > 1) begin
        // Any allocated block, found from a random point; frees the tail from there.
        base = $urandom_range(1, limit - 1);
        for (int i = 0; i < int'(limit) - 1; i++) begin
          probe = 1 + (base - 1 + i) % (limit - 1);
          if (fat_links[probe] != LINK_FREE) begin
            start = BLK_W'(probe);
            break;
          end
        end
      end
    end else begin
      func = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) bytes = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got_val,
                                 input int unsigned want_val);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got_val, want_val);
    error_count++;
  endtask

  // Drives one request after an optional gap and waits for it to be taken. The
  // expectation is queued at the edge that accepts the request, so the model always
  // sees requests in the order the core does.
  task automatic send_request(input logic func, input logic [BYTES_W-1:0] bytes,
                              input logic [BLK_W-1:0] start, input logic typed,
                              input alloc_result_t want);
    alloc_result_t predicted;
    int            gap;
    gap = pick_pause(gap_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= IN_DATA_W'({start, bytes});
    do @(posedge clk); while (!in_tready);
    predicted = predict_fat_request(func, bytes, start);
    pending_results.push_back(typed ? want : predicted);
    if (func == FUNC_ALLOC && predicted.blocks_done != 0)
      chain_heads.push_back(predicted.first_blk);
  endtask

  // Blocks until every request sent so far has produced its result.
  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Holds write enable high; the caller drops it after the last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    set_fat_register(idx, value);
  endtask

  // Result side: the ready line stalls at random, then every accepted result is
  // compared field by field with the oldest outstanding expectation.
  always @(posedge clk) begin : result_ready
    int pause;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pause = pick_pause(stall_pct);
      out_tready <= (pause == 0);
      stall_left <= (pause > 0) ? pause - 1 : 0;
    end
  end

  always @(posedge clk) begin : result_check
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status      = status_t'(out_tdata[2:0]);
      got.first_blk   = out_tdata[14:3];
      got.blocks_done = out_tdata[26:15];
      got.free_left   = out_tdata[38:27];
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding, status", got.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", got.status, want.status);
        if (got.first_blk != want.first_blk)
          report_mismatch("first_block", got.first_blk, want.first_blk);
        if (got.blocks_done != want.blocks_done)
          report_mismatch("blocks_done", got.blocks_done, want.blocks_done);
        if (got.free_left != want.free_left)
          report_mismatch("free_left", got.free_left, want.free_left);
      end
    end
  end

  // Main sequence: reset, directed requests on the reset settings, then the random
  // phases. Registers are only written with no request outstanding.
  initial begin : stimulus
    logic               func;
    logic [BYTES_W-1:0] bytes;
    logic [BLK_W-1:0]   start;
    alloc_result_t      no_result;
    no_result = '0;
    fat_bsize = RESET_BSIZE;
    set_fat_register(CFG_TOTAL_BLOCKS, RESET_TOTAL);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The core clears its table after reset and holds in_tready low meanwhile;
    // the first handshake simply waits that out.
    foreach (DIRECTED_ROWS[r])
      send_request(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].bytes, DIRECTED_ROWS[r].start,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    in_tvalid <= 1'b0;
    wait_results_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      gap_pct   = PHASES[p].gap_pct;
      stall_pct = PHASES[p].stall_pct;
      // Block size goes first: the total_blocks write starts a clearing pass.
      write_register(CFG_BLOCK_SIZE, PHASES[p].bsize);
      if (p == 2) write_register(CFG_UNMAPPED, CFG_DATA_W'($urandom));
      write_register(CFG_TOTAL_BLOCKS, PHASES[p].total);
      cfg_we <= 1'b0;

      for (int i = 0; i < PHASES[p].items; i++) begin
        make_random_request(func, bytes, start);
        send_request(func, bytes, start, 1'b0, no_result);
        // Now and then, and once per phase for sure, let the core run dry before
        // the next request.
        if (i == PHASES[p].items / 2 || $urandom_range(0, 39) == 0) begin
          in_tvalid <= 1'b0;
          wait_results_drained();
        end
      end
      in_tvalid <= 1'b0;
      wait_results_drained();
    end

    // Give a stray extra result time to show up before deciding.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop in case a request or a result never completes.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
